### rtl/lpc_pkg.sv
// Shared types and constants for the LRU page cache.
// Used by lpc_scan, lru_page_cache_unit and the bench files; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

  localparam int PAGE_BITS    = 32;
  localparam int CONTENT_BITS = 32;
  localparam int SLOT_BITS    = 3;
  localparam int CAP_BITS     = 4;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

  typedef struct packed {
    logic [PAGE_BITS-1:0]    page_number;
    logic [CONTENT_BITS-1:0] fill_content;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic [CONTENT_BITS-1:0] content;
    logic [SLOT_BITS-1:0]    slot;
    logic                    evicted;
    logic [PAGE_BITS-1:0]    evicted_page;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

endpackage

`default_nettype wire

### rtl/lpc_scan.sv
// Shared compare unit: looks at one cache entry per cycle while en is high and keeps the
// running hit, least-recent and first-free results. Depends on lpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpc_scan #(
  parameter int IDX_W = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             clr,
  input  wire logic                             en,
  input  wire logic [IDX_W-1:0]                 idx,
  input  wire logic                             ent_valid,
  input  wire logic [IDX_W-1:0]                 ent_rank,
  input  wire logic [lpc_pkg::PAGE_BITS-1:0]    ent_tag,
  input  wire logic [lpc_pkg::CONTENT_BITS-1:0] ent_content,
  input  wire logic [lpc_pkg::PAGE_BITS-1:0]    page,
  output logic                                  hit,
  output logic [IDX_W-1:0]                      hit_idx,
  output logic [IDX_W-1:0]                      hit_rank,
  output logic [lpc_pkg::CONTENT_BITS-1:0]      hit_content,
  output logic                                  lru_found,
  output logic [IDX_W-1:0]                      lru_idx,
  output logic [lpc_pkg::PAGE_BITS-1:0]         lru_tag,
  output logic                                  free_found,
  output logic [IDX_W-1:0]                      free_idx
);

  logic                              hit_r;
  logic [IDX_W-1:0]                  hit_idx_r;
  logic [IDX_W-1:0]                  hit_rank_r;
  logic [lpc_pkg::CONTENT_BITS-1:0]  hit_content_r;
  logic                              lru_found_r;
  logic [IDX_W-1:0]                  lru_idx_r;
  logic [IDX_W-1:0]                  lru_rank_r;
  logic [lpc_pkg::PAGE_BITS-1:0]     lru_tag_r;
  logic                              free_found_r;
  logic [IDX_W-1:0]                  free_idx_r;
  logic                              match;
  logic                              older;
  logic                              is_free;

  assign match   = en && ent_valid && (ent_tag == page) && !hit_r;
  assign older   = en && ent_valid && (!lru_found_r || (ent_rank > lru_rank_r));
  assign is_free = en && !ent_valid && !free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      hit_r        <= 1'b0;
      lru_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (match) begin
        hit_r <= 1'b1;
      end
      if (older) begin
        lru_found_r <= 1'b1;
      end
      if (is_free) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (match) begin
      hit_idx_r     <= idx;
      hit_rank_r    <= ent_rank;
      hit_content_r <= ent_content;
    end
    if (older) begin
      lru_idx_r  <= idx;
      lru_rank_r <= ent_rank;
      lru_tag_r  <= ent_tag;
    end
    if (is_free) begin
      free_idx_r <= idx;
    end
  end

  assign hit         = hit_r;
  assign hit_idx     = hit_idx_r;
  assign hit_rank    = hit_rank_r;
  assign hit_content = hit_content_r;
  assign lru_found   = lru_found_r;
  assign lru_idx     = lru_idx_r;
  assign lru_tag     = lru_tag_r;
  assign free_found  = free_found_r;
  assign free_idx    = free_idx_r;

endmodule

`default_nettype wire

### rtl/lru_page_cache_unit.sv
// Fully associative LRU page cache, top level. Uses lpc_pkg and lpc_scan.
// Each access is scanned one entry per cycle through the tag memory read port
// and the single compare unit; a new access is taken only once the last one has
// left the update step. Next beat may be taken while a result waits. Reset
// clears valid bits, ranks and occupancy and sets capacity to 8; tag and
// content memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_cache_unit #(
  parameter int ENTRIES = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire lpc_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output lpc_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_we,
  input  wire logic [lpc_pkg::CAP_BITS-1:0]       cfg_wdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > lpc_pkg::CAP_BITS) ? OCC_W : lpc_pkg::CAP_BITS;
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ENTRIES);

  lpc_pkg::state_t                    state_r, state_nxt;
  logic [lpc_pkg::CAP_BITS-1:0]       cap_r;
  logic [OCC_W-1:0]                   occ_r, occ_nxt;
  logic [ENTRIES-1:0]                 valid_r, valid_nxt;
  logic [IDX_W-1:0]                   rank_r   [ENTRIES];
  logic [IDX_W-1:0]                   rank_nxt [ENTRIES];
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic                               cmp_en_r;
  logic [IDX_W-1:0]                   cmp_idx_r;
  logic [lpc_pkg::PAGE_BITS-1:0]      page_r;
  logic [lpc_pkg::CONTENT_BITS-1:0]   fill_r;
  logic                               out_valid_r;
  lpc_pkg::out_item_t                 out_data_r;

  logic [lpc_pkg::PAGE_BITS-1:0]      tag_mem  [ENTRIES];
  logic [lpc_pkg::CONTENT_BITS-1:0]   cont_mem [ENTRIES];
  logic [lpc_pkg::PAGE_BITS-1:0]      tag_rd_r;
  logic [lpc_pkg::CONTENT_BITS-1:0]   cont_rd_r;

  logic                               in_fire;
  logic                               scan_rd;
  logic [IDX_W-1:0]                   rd_addr;
  logic                               upd_go;
  logic                               miss_wr;
  logic [CW-1:0]                      cap_ext;
  logic [CW-1:0]                      eff_cap;
  logic                               full;
  logic                               evict;
  logic [IDX_W-1:0]                   target;

  logic                               sc_hit;
  logic [IDX_W-1:0]                   sc_hit_idx;
  logic [IDX_W-1:0]                   sc_hit_rank;
  logic [lpc_pkg::CONTENT_BITS-1:0]   sc_hit_content;
  logic                               sc_lru_found;
  logic [IDX_W-1:0]                   sc_lru_idx;
  logic [lpc_pkg::PAGE_BITS-1:0]      sc_lru_tag;
  logic                               sc_free_found;
  logic [IDX_W-1:0]                   sc_free_idx;

  assign in_ready  = (state_r == lpc_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign scan_rd   = (state_r == lpc_pkg::ST_SCAN) && (cnt_r < SCAN_END);
  assign rd_addr   = cnt_r[IDX_W-1:0];
  assign upd_go    = (state_r == lpc_pkg::ST_UPD) && (!out_valid_r || out_ready);
  assign miss_wr   = upd_go && !sc_hit;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp capacity: zero acts as one, anything past the build size as ENTRIES.
  assign cap_ext = CW'(cap_r);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full   = CW'(occ_r) >= eff_cap;
  assign evict  = full && sc_lru_found;
  assign target = evict ? sc_lru_idx : sc_free_idx;

  lpc_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (in_fire),
    .en          (cmp_en_r),
    .idx         (cmp_idx_r),
    .ent_valid   (valid_r[cmp_idx_r]),
    .ent_rank    (rank_r[cmp_idx_r]),
    .ent_tag     (tag_rd_r),
    .ent_content (cont_rd_r),
    .page        (page_r),
    .hit         (sc_hit),
    .hit_idx     (sc_hit_idx),
    .hit_rank    (sc_hit_rank),
    .hit_content (sc_hit_content),
    .lru_found   (sc_lru_found),
    .lru_idx     (sc_lru_idx),
    .lru_tag     (sc_lru_tag),
    .free_found  (sc_free_found),
    .free_idx    (sc_free_idx)
  );

  // Sequencer and cache bookkeeping.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    occ_nxt   = occ_r;
    valid_nxt = valid_r;
    for (int j = 0; j < ENTRIES; j++) begin
      rank_nxt[j] = rank_r[j];
    end
    case (state_r)
      lpc_pkg::ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt   = '0;
          state_nxt = lpc_pkg::ST_SCAN;
        end
      end
      lpc_pkg::ST_SCAN: begin
        if (cnt_r < SCAN_END) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = lpc_pkg::ST_UPD;
        end
      end
      lpc_pkg::ST_UPD: begin
        if (upd_go) begin
          state_nxt = lpc_pkg::ST_IDLE;
          if (sc_hit) begin
            // Entries more recent than the hit age by one; the hit goes to front.
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_r[j] && (rank_r[j] < sc_hit_rank)) begin
                rank_nxt[j] = rank_r[j] + IDX_W'(1);
              end
            end
            rank_nxt[sc_hit_idx] = '0;
          end else begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (valid_r[j] && (IDX_W'(j) != target)) begin
                rank_nxt[j] = rank_r[j] + IDX_W'(1);
              end
            end
            rank_nxt[target]  = '0;
            valid_nxt[target] = 1'b1;
            if (!evict) begin
              occ_nxt = occ_r + OCC_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = lpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpc_pkg::ST_IDLE;
      cap_r       <= lpc_pkg::CAP_RESET;
      occ_r       <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      valid_r  <= valid_nxt;
      cnt_r    <= cnt_nxt;
      cmp_en_r <= scan_rd;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_addr;
    if (in_fire) begin
      page_r <= in_data.page_number;
      fill_r <= in_data.fill_content;
    end
    if (upd_go) begin
      out_data_r.hit          <= sc_hit;
      out_data_r.content      <= sc_hit ? sc_hit_content : fill_r;
      out_data_r.slot         <= lpc_pkg::SLOT_BITS'(sc_hit ? sc_hit_idx : target);
      out_data_r.evicted      <= !sc_hit && evict;
      out_data_r.evicted_page <= (!sc_hit && evict) ? sc_lru_tag : '0;
    end
  end

  // Tag and content memories: one read port for the scan, one write on a miss.
  always_ff @(posedge clk) begin
    if (scan_rd) begin
      tag_rd_r  <= tag_mem[rd_addr];
      cont_rd_r <= cont_mem[rd_addr];
    end
    if (miss_wr) begin
      tag_mem[target]  <= page_r;
      cont_mem[target] <= fill_r;
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy differs from valid entry count");

  a_miss_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    miss_wr |-> (evict || sc_free_found))
    else $error("miss found neither a victim nor a free entry");

  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lpc_pkg::ST_UPD))
    else $error("result raised outside the update step");

  a_scan_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_en_r |-> (state_r == lpc_pkg::ST_SCAN))
    else $error("compare unit active outside the scan");

endmodule

`default_nettype wire

### bench/lru_page_cache_checker.sv
// Scoreboard for the LRU page cache: watches the access, result and capacity ports,
// keeps its own copy of tags, contents, valid bits, ranks and occupancy, and
// compares every result beat with its prediction. Needs lpc_pkg.
`timescale 1ns / 1ps

module lru_page_cache_checker #(
  parameter int ENTRIES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  lpc_pkg::in_item_t                in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  lpc_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [lpc_pkg::CAP_BITS-1:0]     cfg_wdata,
  output int                               fail_count,
  output int                               pending
);

  logic [lpc_pkg::PAGE_BITS-1:0]    tags     [ENTRIES];
  logic [lpc_pkg::CONTENT_BITS-1:0] contents [ENTRIES];
  bit                               present  [ENTRIES];
  int unsigned                      ranks    [ENTRIES];
  int unsigned                      occupied;
  logic [lpc_pkg::CAP_BITS-1:0]     capacity;
  lpc_pkg::out_item_t               expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned capacity_in_use();
    if (capacity == '0) return 1;
    if (capacity > ENTRIES) return ENTRIES;
    return capacity;
  endfunction

  // One lookup: update the shadow store and return the result it must produce.
  function automatic lpc_pkg::out_item_t predict_access(input lpc_pkg::in_item_t beat);
    lpc_pkg::out_item_t res;
    int                 found;
    int                 target;
    int unsigned        oldest;
    int unsigned        hit_rank;
    found  = -1;
    target = -1;
    oldest = 0;
    res    = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && present[i] && tags[i] == beat.page_number) found = i;
    if (found >= 0) begin
      hit_rank = ranks[found];
      for (int i = 0; i < ENTRIES; i++)
        if (present[i] && ranks[i] < hit_rank) ranks[i]++;
      ranks[found] = 0;
      res.hit     = 1'b1;
      res.content = contents[found];
      res.slot    = found[lpc_pkg::SLOT_BITS-1:0];
      return res;
    end
    // Full: drop the least recent entry and reuse its slot.
    if (occupied >= capacity_in_use()) begin
      for (int i = 0; i < ENTRIES; i++)
        if (present[i] && (target < 0 || ranks[i] > oldest)) begin
          target = i;
          oldest = ranks[i];
        end
      if (target >= 0) begin
        res.evicted      = 1'b1;
        res.evicted_page = tags[target];
        present[target]  = 1'b0;
        occupied--;
      end
    end
    if (target < 0)
      for (int i = 0; i < ENTRIES; i++)
        if (target < 0 && !present[i]) target = i;
    for (int i = 0; i < ENTRIES; i++)
      if (present[i]) ranks[i]++;
    tags[target]     = beat.page_number;
    contents[target] = beat.fill_content;
    present[target]  = 1'b1;
    ranks[target]    = 0;
    occupied++;
    res.content = beat.fill_content;
    res.slot    = target[lpc_pkg::SLOT_BITS-1:0];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lpc_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        present[i] = 1'b0;
        ranks[i]   = 0;
      end
      occupied = 0;
      capacity = lpc_pkg::CAP_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      // Retire the result beat first: it always belongs to an older access.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no access waiting: %p", out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", want.hit, out_data.hit);
          check_field("content", want.content, out_data.content);
          check_field("slot", want.slot, out_data.slot);
          check_field("evicted", want.evicted, out_data.evicted);
          check_field("evicted_page", want.evicted_page, out_data.evicted_page);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_access(in_data));
    end
    pending = expected_results.size();
  end

endmodule

### bench/lru_page_cache_unit_tb.sv
// Top of the LRU page cache testbench: clock, reset, access and capacity stimulus,
// result back-pressure and verdict. Needs lpc_pkg, lru_page_cache_unit and
// lru_page_cache_checker.
`timescale 1ns / 1ps

module lru_page_cache_unit_tb;

  localparam int ENTRIES         = 8;
  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int LONG_HOLD       = 400;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = ENTRIES + 8;
  localparam int PHASE_CAPS [NUM_PHASES] = '{8, 3, 15, 1, 5, 0, 2, 7, 12, 4, 6};

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  lpc_pkg::in_item_t            in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  lpc_pkg::out_item_t           out_data;
  logic                         cfg_we    = 1'b0;
  logic [lpc_pkg::CAP_BITS-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit burst_mode  = 1'b0;
  bit hold_req    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_page_cache_unit #(.ENTRIES(ENTRIES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lru_page_cache_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mostly back-to-back, sometimes a few cycles, rarely a long gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  // when no gap follows, so the next beat goes out without a bubble.
  task automatic send_access(input logic [31:0] page, input logic [31:0] fill);
    lpc_pkg::in_item_t beat;
    int                gap;
    beat.page_number  = page;
    beat.fill_content = fill;
    in_data  = beat;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [lpc_pkg::CAP_BITS-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Result side: random stalls, none in burst phases, one long hold on request.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (burst_mode || $urandom_range(0, 99) < 60) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        gap = pick_gap();
        repeat (gap) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] page_pool [16];
    int          pool_n;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Small capacity while the store is still empty: evict before it fills.
    write_capacity(4'd2);
    send_access(32'h0000_0000, 32'h0000_0000);
    send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(32'h0000_0000, 32'h0000_0001);  // hit on the least recent entry
    send_access(32'h0000_0000, 32'h0000_0002);  // hit on the most recent entry
    send_access(32'h8000_0000, 32'hA5A5_A5A5);
    drain_results();

    // Full size: remaining misses take the lowest free slots, then evict.
    write_capacity(4'd8);
    for (int p = 1; p <= 6; p++) send_access(p, ~p);
    send_access(32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_access(32'h0000_0003, 32'h0000_0000);
    drain_results();

    // Shrink below occupancy: one eviction per miss, surplus pages still hit.
    write_capacity(4'd1);
    send_access(32'hDEAD_BEEF, 32'h0000_0000);
    send_access(32'h0000_0004, 32'h0000_0000);
    send_access(32'hDEAD_BEEF, 32'hFFFF_FFFF);
    drain_results();

    // Zero behaves as one, anything above the entry count as the entry count.
    write_capacity(4'd0);
    send_access(32'h5555_5555, 32'hFFFF_FFFF);
    send_access(32'hAAAA_AAAA, 32'h0000_0000);
    drain_results();
    write_capacity(4'd15);
    send_access(32'h1234_5678, 32'h8765_4321);
    send_access(32'hAAAA_AAAA, 32'h0000_0001);

    // Random phases: mostly a small page pool for hits, some fresh pages.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_capacity(PHASE_CAPS[ph][lpc_pkg::CAP_BITS-1:0]);
      burst_mode = (ph == 2 || ph == 6);
      pool_n = $urandom_range(2, 16);
      foreach (page_pool[k]) page_pool[k] = $urandom();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 40) hold_req = 1'b1;
        if ($urandom_range(0, 99) < 85)
          send_access(page_pool[$urandom_range(0, pool_n - 1)], $urandom());
        else
          send_access($urandom(), $urandom());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### lru_page_cache_unit.f
rtl/lpc_pkg.sv
rtl/lpc_scan.sv
rtl/lru_page_cache_unit.sv
bench/lru_page_cache_checker.sv
bench/lru_page_cache_unit_tb.sv
